>>> rtl/fir_lpf_pkg.sv
// ----------------------------------------------------------------------------
// fir_lpf_pkg
// Shared types and constants of the two-channel FIR low-pass filter:
// request payloads, function codes, register map and sequencer states.
// ----------------------------------------------------------------------------
package fir_lpf_pkg;

    // Function codes of an input request (the fourth code is ignored)
    localparam logic [1:0] FUNC_LOAD   = 2'd0;
    localparam logic [1:0] FUNC_SAMPLE = 2'd1;
    localparam logic [1:0] FUNC_CLEAR  = 2'd2;

    // Register map: index i sits at byte address 4*i
    localparam int         CFG_ADDR_W       = 4;
    localparam logic [1:0] REG_WINDOW_SEL   = 2'd0;
    localparam logic [1:0] REG_EIGHT_BIT    = 2'd1;
    localparam logic [1:0] REG_FILTER_EN    = 2'd2;

    // Register reset values
    localparam logic [2:0] WINDOW_SEL_RESET = 3'd2;
    localparam logic       EIGHT_BIT_RESET  = 1'b0;
    localparam logic       FILTER_EN_RESET  = 1'b1;

    // Window size is 2^(WIN_LOG_BASE + select), select capped at WIN_SEL_MAX
    localparam logic [2:0] WIN_SEL_MAX      = 3'd4;
    localparam logic [3:0] WIN_LOG_BASE     = 4'd4;

    // Output clamp limits
    localparam int SAT16_LO = -32768;
    localparam int SAT16_HI = 32767;
    localparam int SAT8_LO  = -128;
    localparam int SAT8_HI  = 127;

    // Input request payload
    typedef struct packed {
        logic [1:0]          func;
        logic                channel;
        logic [7:0]          coeff_index;
        logic signed [15:0]  coeff_value;
        logic signed [15:0]  sample_value;
        logic                last_in_block;
    } in_item_t;

    // Result request payload
    typedef struct packed {
        logic signed [15:0]  filtered_sample;
        logic                out_channel;
        logic                end_of_block;
        logic                saturated;
    } out_item_t;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_CLEAR_CH,
        ST_MAC,
        ST_DRAIN,
        ST_SCALE,
        ST_EMIT
    } state_t;

endpackage

>>> rtl/fir_lpf_ram.sv
// ----------------------------------------------------------------------------
// fir_lpf_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module fir_lpf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/fir_lowpass_filter_top.sv
// ----------------------------------------------------------------------------
// fir_lowpass_filter_top
// Two-channel direct-form FIR low-pass with one shared multiply-accumulate
// unit stepping over the taps, a coefficient RAM and a history ring RAM.
// ----------------------------------------------------------------------------
// Sample request (filter on): the MAC loop issues one tap per cycle for W-1
//   taps, W = window, plus read, multiply and accumulate stages, a scale
//   state and an emit state; a new request is taken once the state is back
//   in idle. Filter off: the sample goes straight to the emit state.
// Load request: block stays idle. Clear request: sweeps MAX_WINDOW ring entries.
// Reset: synchronous, active low; afterwards the history ring is zeroed in a
//   pass over CHANNELS*MAX_WINDOW entries with s_ready low (APB still works).
// ----------------------------------------------------------------------------
module fir_lowpass_filter_top #(
    parameter int MAX_WINDOW      = 256,  // power of two, 16..256
    parameter int CHANNELS        = 2,
    parameter int COEFF_FRAC_BITS = 15
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // input requests
    input  logic                               s_valid,
    output logic                               s_ready,
    input  fir_lpf_pkg::in_item_t              s_data,
    // result requests
    output logic                               m_valid,
    input  logic                               m_ready,
    output fir_lpf_pkg::out_item_t             m_data,
    // configuration
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [fir_lpf_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);
    import fir_lpf_pkg::*;

    localparam int AW    = $clog2(MAX_WINDOW);
    localparam int DEPTH = CHANNELS * MAX_WINDOW;
    localparam int RAW   = $clog2(DEPTH);
    localparam int ACC_W = 32 + AW;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [2:0] window_sel_reg;
    logic       eight_bit_reg;
    logic       filter_en_reg;
    logic       cfg_write;
    logic [1:0] cfg_index;

    assign pready    = 1'b1;
    assign cfg_index = paddr[3:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_sel_reg <= WINDOW_SEL_RESET;
            eight_bit_reg  <= EIGHT_BIT_RESET;
            filter_en_reg  <= FILTER_EN_RESET;
        end else if (cfg_write) begin
            case (cfg_index)
                REG_WINDOW_SEL: window_sel_reg <= pwdata[2:0];
                REG_EIGHT_BIT:  eight_bit_reg  <= pwdata[0];
                REG_FILTER_EN:  filter_en_reg  <= pwdata[0];
                default: ;
            endcase
        end
    end

    // Read back
    always_comb begin
        case (cfg_index)
            REG_WINDOW_SEL: prdata = {29'd0, window_sel_reg};
            REG_EIGHT_BIT:  prdata = {31'd0, eight_bit_reg};
            REG_FILTER_EN:  prdata = {31'd0, filter_en_reg};
            default:        prdata = 32'd0;
        endcase
    end

    // ------------------------------------------------------------------
    // Window mask: window size minus one, capped at MAX_WINDOW
    // ------------------------------------------------------------------
    logic [2:0]  sel_clamped;
    logic [3:0]  win_log;
    logic [AW:0] win_size;
    logic [AW-1:0] win_mask;

    always_comb begin
        sel_clamped = (window_sel_reg > WIN_SEL_MAX) ? WIN_SEL_MAX : window_sel_reg;
        win_log     = WIN_LOG_BASE + {1'b0, sel_clamped};
        if (32'(win_log) > AW) begin
            win_log = 4'(AW);
        end
        win_size = (AW + 1)'(1) << win_log;
        win_mask = AW'(win_size - 1'b1);
    end

    // ------------------------------------------------------------------
    // State and datapath registers
    // ------------------------------------------------------------------
    state_t             state_reg, state_next;
    logic [RAW-1:0]     clr_cnt_reg;
    logic [AW-1:0]      k_reg;
    logic [AW-1:0]      wp_reg [2];
    logic [AW-1:0]      pos_reg;
    logic               ch_reg;
    logic               last_reg;
    logic               bypass_reg;
    logic signed [15:0] sample_reg;
    logic               rd_v_reg, rd_last_reg;
    logic               mul_v_reg, mul_last_reg;
    logic signed [31:0] prod_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] v_reg;
    logic               out_valid_reg;
    out_item_t          out_data_reg;

    // Request decode
    logic           s_accept;
    logic           ch_ok;
    logic [AW-1:0]  in_pos;
    logic           take_sample;
    logic           take_load;
    logic           take_clear;
    logic           out_free;
    logic           clr_ch_done;
    logic           init_done;
    logic           mac_last;

    assign s_accept    = s_valid && s_ready;
    assign ch_ok       = 32'(s_data.channel) < CHANNELS;
    assign in_pos      = wp_reg[s_data.channel] & win_mask;
    assign take_sample = s_accept && ch_ok && (s_data.func == FUNC_SAMPLE);
    assign take_load   = s_accept && ch_ok && (s_data.func == FUNC_LOAD)
                         && (32'(s_data.coeff_index) < MAX_WINDOW);
    assign take_clear  = s_accept && ch_ok && (s_data.func == FUNC_CLEAR);
    assign out_free    = !out_valid_reg || m_ready;
    assign clr_ch_done = (clr_cnt_reg[AW-1:0] == {AW{1'b1}});
    assign init_done   = (clr_cnt_reg == RAW'(DEPTH - 1));
    assign mac_last    = (k_reg == win_mask - 1'b1);

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_INIT: begin
                if (init_done) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (take_clear) begin
                    state_next = ST_CLEAR_CH;
                end else if (take_sample) begin
                    state_next = filter_en_reg ? ST_MAC : ST_EMIT;
                end
            end
            ST_CLEAR_CH: begin
                if (clr_ch_done) state_next = ST_IDLE;
            end
            ST_MAC: begin
                if (mac_last) state_next = ST_DRAIN;
            end
            ST_DRAIN: begin
                if (mul_v_reg && mul_last_reg) state_next = ST_SCALE;
            end
            ST_SCALE: begin
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_INIT;
        endcase
    end

    // ------------------------------------------------------------------
    // Memory port controls and handshake outputs
    // ------------------------------------------------------------------
    logic               ring_we;
    logic [RAW-1:0]     ring_waddr;
    logic [15:0]        ring_wdata;
    logic [RAW-1:0]     ring_raddr;
    logic [15:0]        ring_rdata;
    logic               coef_we;
    logic [AW-1:0]      coef_waddr;
    logic [AW-1:0]      coef_raddr;
    logic [15:0]        coef_rdata;
    logic [AW-1:0]      tap_idx;

    always_comb begin
        s_ready    = (state_reg == ST_IDLE);
        ring_we    = 1'b0;
        ring_waddr = clr_cnt_reg;
        ring_wdata = 16'd0;
        tap_idx    = (pos_reg - k_reg) & win_mask;
        ring_raddr = RAW'({ch_reg, tap_idx});
        coef_raddr = k_reg;
        coef_we    = take_load;
        coef_waddr = AW'(s_data.coeff_index);
        case (state_reg)
            ST_INIT: begin
                ring_we = 1'b1;
            end
            ST_CLEAR_CH: begin
                ring_we    = 1'b1;
                ring_waddr = RAW'({ch_reg, clr_cnt_reg[AW-1:0]});
            end
            ST_IDLE: begin
                ring_we    = take_sample && filter_en_reg;
                ring_waddr = RAW'({s_data.channel, in_pos});
                ring_wdata = s_data.sample_value;
            end
            default: ;
        endcase
    end

    fir_lpf_ram #(
        .WIDTH (16),
        .DEPTH (DEPTH)
    ) u_ring_ram (
        .aclk  (aclk),
        .we    (ring_we),
        .waddr (ring_waddr),
        .wdata (ring_wdata),
        .raddr (ring_raddr),
        .rdata (ring_rdata)
    );

    fir_lpf_ram #(
        .WIDTH (16),
        .DEPTH (MAX_WINDOW)
    ) u_coef_ram (
        .aclk  (aclk),
        .we    (coef_we),
        .waddr (coef_waddr),
        .wdata (s_data.coeff_value),
        .raddr (coef_raddr),
        .rdata (coef_rdata)
    );

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_INIT;
            clr_cnt_reg   <= '0;
            k_reg         <= '0;
            wp_reg[0]     <= '0;
            wp_reg[1]     <= '0;
            rd_v_reg      <= 1'b0;
            rd_last_reg   <= 1'b0;
            mul_v_reg     <= 1'b0;
            mul_last_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;

            // Advance the clearing sweep; restart it for a channel clear
            if (state_reg == ST_INIT || state_reg == ST_CLEAR_CH) begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end else begin
                clr_cnt_reg <= '0;
            end

            // Tap counter
            if (state_reg == ST_MAC) begin
                k_reg <= k_reg + 1'b1;
            end else begin
                k_reg <= '0;
            end

            // Write positions
            if (take_clear) begin
                wp_reg[s_data.channel] <= '0;
            end else if (take_sample && filter_en_reg) begin
                wp_reg[s_data.channel] <= (in_pos + 1'b1) & win_mask;
            end

            // MAC pipeline valids
            rd_v_reg     <= (state_reg == ST_MAC);
            rd_last_reg  <= (state_reg == ST_MAC) && mac_last;
            mul_v_reg    <= rd_v_reg;
            mul_last_reg <= rd_last_reg;

            // Output register: drop on take, load on emit
            if (state_reg == ST_EMIT && out_free) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Datapath registers
    // ------------------------------------------------------------------
    logic signed [ACC_W-1:0] acc_shr;
    logic                    round_up;
    logic signed [ACC_W-1:0] lim_lo, lim_hi;
    logic signed [15:0]      emit_value;
    logic                    emit_sat;

    // Scale by 2^-F with truncation toward zero
    always_comb begin
        acc_shr  = acc_reg >>> COEFF_FRAC_BITS;
        round_up = acc_reg[ACC_W-1] && (|acc_reg[COEFF_FRAC_BITS-1:0]);
    end

    // Clamp to the selected output range; in bypass the sample passes unclamped
    always_comb begin
        lim_lo = eight_bit_reg ? ACC_W'(SAT8_LO) : ACC_W'(SAT16_LO);
        lim_hi = eight_bit_reg ? ACC_W'(SAT8_HI) : ACC_W'(SAT16_HI);
        if (bypass_reg) begin
            emit_value = sample_reg;
            emit_sat   = 1'b0;
        end else if (v_reg < lim_lo) begin
            emit_value = lim_lo[15:0];
            emit_sat   = 1'b1;
        end else if (v_reg > lim_hi) begin
            emit_value = lim_hi[15:0];
            emit_sat   = 1'b1;
        end else begin
            emit_value = v_reg[15:0];
            emit_sat   = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        // Capture the request
        if (s_accept) begin
            ch_reg     <= s_data.channel;
            last_reg   <= s_data.last_in_block;
            sample_reg <= s_data.sample_value;
            pos_reg    <= in_pos;
            bypass_reg <= !filter_en_reg;
        end

        // Multiply, then accumulate
        prod_reg <= $signed(coef_rdata) * $signed(ring_rdata);
        if (s_accept) begin
            acc_reg <= '0;
        end else if (mul_v_reg) begin
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        end

        if (state_reg == ST_SCALE) begin
            v_reg <= acc_shr + $signed({{(ACC_W-1){1'b0}}, round_up});
        end

        if (state_reg == ST_EMIT && out_free) begin
            out_data_reg.filtered_sample <= emit_value;
            out_data_reg.out_channel     <= ch_reg;
            out_data_reg.end_of_block    <= last_reg;
            out_data_reg.saturated       <= emit_sat;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule

>>> rtl/fir_lpf_checker.sv
// ----------------------------------------------------------------------------
// fir_lpf_checker
// Port-level checks of the FIR low-pass filter, bound to the top level.
// ----------------------------------------------------------------------------
module fir_lpf_checker #(
    parameter int CHANNELS = 2
) (
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   s_valid,
    input logic                   s_ready,
    input fir_lpf_pkg::in_item_t  s_data,
    input logic                   m_valid,
    input logic                   m_ready,
    input fir_lpf_pkg::out_item_t m_data
);
    import fir_lpf_pkg::*;

    // Reset empties the output and holds off requests during the ring sweep
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !s_ready && !m_valid)
        else $error("request taken or result shown right after reset");

    // A sample request always keeps the block busy, dropping ready
    a_sample_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_data.func == FUNC_SAMPLE
        && 32'(s_data.channel) < CHANNELS |=> !s_ready)
        else $error("ready stayed high after a sample request");

    // A stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // A clamped result sits on one of the clamp limits
    a_sat_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.saturated |->
            m_data.filtered_sample == 16'sd32767
            || m_data.filtered_sample == -16'sd32768
            || m_data.filtered_sample == 16'sd127
            || m_data.filtered_sample == -16'sd128)
        else $error("saturated result off the clamp limits");

endmodule

bind fir_lowpass_filter_top fir_lpf_checker #(.CHANNELS(CHANNELS)) u_fir_lpf_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
